>>> hdl/bpa_pkg.sv
// bpa_pkg: shared types, constants and helpers of the block pool bump allocator
// depends on nothing; every other file of the block imports it
package bpa_pkg;

   // pool sizing
   localparam int MAX_BLOCKS   = 16;
   localparam int MAX_ONESHOTS = 16;
   localparam int IDX_W        = $clog2(MAX_BLOCKS);
   localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
   localparam int OS_W         = $clog2(MAX_ONESHOTS + 1);
   localparam int USED_SUM_W   = $clog2(MAX_BLOCKS + MAX_ONESHOTS + 2);

   // fixed field widths
   localparam int ID_W     = 8;
   localparam int SIZE_W   = 32;
   localparam int OFF_W    = 24;
   localparam int BSZ_W    = 25;
   localparam int ALIGN_W  = 4;
   localparam int USED_W   = 6;
   localparam int RND_W    = SIZE_W + 1;
   localparam int MASK_W   = 13;

   localparam logic [ALIGN_W-1:0] ALIGN_MAX   = 4'd12;
   localparam logic [ALIGN_W-1:0] ALIGN_RESET = 4'd8;
   localparam logic [BSZ_W-1:0]   BSZ_MAX     = 25'd16777216;
   localparam logic [BSZ_W-1:0]   BSZ_RESET   = 25'd65536;
   localparam logic [OFF_W-1:0]   OFF_SAT     = 24'hFFFFFF;

   // request command codes
   typedef enum logic [0:0] {
      CMD_ALLOC       = 1'b0,
      CMD_FRAME_RESET = 1'b1
   } cmd_type;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_ALIGN_LOG2 = 1'b0,
      CSR_BLOCK_SIZE = 1'b1
   } csr_index_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RD,
      ST_WR,
      ST_FIN
   } state_type;

   // effective configuration, already clamped
   typedef struct packed {
      logic [ALIGN_W-1:0] align_log2;
      logic [BSZ_W-1:0]   block_size;
   } cfg_type;

   // control of the two id stacks
   typedef struct packed {
      logic             free_we;
      logic [IDX_W-1:0] free_waddr;
      logic [ID_W-1:0]  free_wdata;
      logic [IDX_W-1:0] free_raddr;
      logic             rec_we;
      logic [IDX_W-1:0] rec_waddr;
      logic [ID_W-1:0]  rec_wdata;
      logic [IDX_W-1:0] rec_raddr;
   } stk_ctl_type;

   // registered read data of the two id stacks
   typedef struct packed {
      logic [ID_W-1:0] free_top;
      logic [ID_W-1:0] rec_entry;
   } stk_dat_type;

   // round a value up to a multiple of 2^lg
   function automatic logic [RND_W-1:0] round_up(input logic [RND_W-1:0] v,
                                                 input logic [ALIGN_W-1:0] lg);
      logic [MASK_W-1:0] m;
      logic [RND_W-1:0]  mx;
      m  = (MASK_W'(1) << lg) - MASK_W'(1);
      mx = RND_W'(m);
      return (v + mx) & ~mx;
   endfunction

endpackage

>>> hdl/bpa_if.sv
// bpa_if: valid/ready channel interfaces for request, response and register writes
// depends on bpa_pkg
interface bpa_req_if;
   import bpa_pkg::*;
   logic             valid;
   logic             ready;
   cmd_type          cmd;
   logic [SIZE_W-1:0] req_size;
   modport source (output valid, cmd, req_size, input ready);
   modport sink   (input valid, cmd, req_size, output ready);
endinterface

interface bpa_rsp_if;
   import bpa_pkg::*;
   logic              valid;
   logic              ready;
   logic [ID_W-1:0]   block_id;
   logic              is_oversized;
   logic [OFF_W-1:0]  offset;
   logic [SIZE_W-1:0] granted_size;
   logic              fresh_block;
   logic [USED_W-1:0] used_blocks;
   logic              fault;
   modport source (output valid, block_id, is_oversized, offset, granted_size,
                   fresh_block, used_blocks, fault, input ready);
   modport sink   (input valid, block_id, is_oversized, offset, granted_size,
                   fresh_block, used_blocks, fault, output ready);
endinterface

interface bpa_csr_if;
   import bpa_pkg::*;
   logic              valid;
   logic              ready;
   csr_index_type     index;
   logic [BSZ_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/bpa_csr.sv
// bpa_csr: configuration registers, clamped to their usable range on write
// depends on bpa_pkg and bpa_csr_if
module bpa_csr (
   input  logic             clock,
   input  logic             reset,
   bpa_csr_if.sink          csr_bus,
   output bpa_pkg::cfg_type cfg
);
   import bpa_pkg::*;

   logic [ALIGN_W-1:0] align_ff, align_in;
   logic [BSZ_W-1:0]   bsz_ff, bsz_in;
   logic [ALIGN_W-1:0] wr_align;

   assign csr_bus.ready = !reset;
   assign wr_align      = csr_bus.data[ALIGN_W-1:0];

   // decode a write beat and clamp the value
   always_comb begin
      align_in = align_ff;
      bsz_in   = bsz_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_ALIGN_LOG2: begin
               align_in = (wr_align > ALIGN_MAX) ? ALIGN_MAX : wr_align;
            end
            CSR_BLOCK_SIZE: begin
               if (csr_bus.data == '0) begin
                  bsz_in = BSZ_W'(1);
               end else if (csr_bus.data > BSZ_MAX) begin
                  bsz_in = BSZ_MAX;
               end else begin
                  bsz_in = csr_bus.data;
               end
            end
            default: begin
               bsz_in = bsz_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         align_ff <= ALIGN_RESET;
         bsz_ff   <= BSZ_RESET;
      end else begin
         align_ff <= align_in;
         bsz_ff   <= bsz_in;
      end
   end

   assign cfg.align_log2 = align_ff;
   assign cfg.block_size = bsz_ff;

   // stored values never leave the usable range
   a_align_range: assert property (@(posedge clock) disable iff (reset)
      align_ff <= ALIGN_MAX)
      else $error("alignment register above limit");
   a_bsz_range: assert property (@(posedge clock) disable iff (reset)
      (bsz_ff != '0) && (bsz_ff <= BSZ_MAX))
      else $error("block size register out of range");
   a_write_lands: assert property (@(posedge clock) disable iff (reset)
      (csr_bus.valid && csr_bus.index == CSR_ALIGN_LOG2
       && csr_bus.data[ALIGN_W-1:0] <= ALIGN_MAX)
      |=> align_ff == $past(csr_bus.data[ALIGN_W-1:0]))
      else $error("alignment write lost");

endmodule

>>> hdl/bpa_stacks.sv
// bpa_stacks: free-stack and recycle-list memories, one write and one
// registered read port each; depends on bpa_pkg
module bpa_stacks (
   input  logic                 clock,
   input  bpa_pkg::stk_ctl_type ctl,
   output bpa_pkg::stk_dat_type dat
);
   import bpa_pkg::*;

   logic [ID_W-1:0] free_mem [MAX_BLOCKS];
   logic [ID_W-1:0] rec_mem  [MAX_BLOCKS];
   logic [ID_W-1:0] free_rd_ff;
   logic [ID_W-1:0] rec_rd_ff;

   // free stack: write port and registered read
   always_ff @(posedge clock) begin
      if (ctl.free_we) begin
         free_mem[ctl.free_waddr] <= ctl.free_wdata;
      end
      free_rd_ff <= free_mem[ctl.free_raddr];
   end

   // recycle list: write port and registered read
   always_ff @(posedge clock) begin
      if (ctl.rec_we) begin
         rec_mem[ctl.rec_waddr] <= ctl.rec_wdata;
      end
      rec_rd_ff <= rec_mem[ctl.rec_raddr];
   end

   assign dat.free_top  = free_rd_ff;
   assign dat.rec_entry = rec_rd_ff;

endmodule

>>> hdl/block_pool_bump_allocator_top.sv
// Block pool bump allocator. An allocate beat passes through ST_EXEC: the accept
// cycle rounds the size and reads the top of the free stack, and ST_EXEC finishes
// the allocation with that read data and loads the response register once the
// response register is free. A frame reset beat walks the recycle list in ST_RD
// and ST_WR: each recycled id is read from the recycle-list memory and written to
// the free-stack memory, then ST_FIN loads the response. The next request beat is accepted in the cycle
// after a response is loaded, even while that response still waits to be taken.
// No clearing pass runs after reset. Depends on bpa_pkg, bpa_if, bpa_csr and
// bpa_stacks.
module block_pool_bump_allocator_top (
   input  logic       clock,
   input  logic       reset,
   bpa_req_if.sink    req_bus,
   bpa_rsp_if.source  rsp_bus,
   bpa_csr_if.sink    csr_bus
);
   import bpa_pkg::*;

   cfg_type     cfg;
   stk_ctl_type stk_ctl;
   stk_dat_type stk_dat;

   state_type state_ff, state_in;

   // latched request
   cmd_type           cmd_ff, cmd_in;
   logic [SIZE_W-1:0] req_size_ff, req_size_in;
   logic [BSZ_W-1:0]  asz_ff, asz_in;
   logic              over_ff, over_in;
   logic [BSZ_W:0]    pos_ff, pos_in;

   // allocator state
   logic              cur_valid_ff, cur_valid_in;
   logic [ID_W-1:0]   cur_block_ff, cur_block_in;
   logic [BSZ_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  free_count_ff, free_count_in;
   logic [CNT_W-1:0]  recycle_count_ff, recycle_count_in;
   logic [CNT_W-1:0]  next_fresh_ff, next_fresh_in;
   logic [OS_W-1:0]   oneshot_ff, oneshot_in;
   logic [CNT_W-1:0]  walk_idx_ff, walk_idx_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]   rsp_block_id_ff, rsp_block_id_in;
   logic              rsp_over_ff, rsp_over_in;
   logic [OFF_W-1:0]  rsp_offset_ff, rsp_offset_in;
   logic [SIZE_W-1:0] rsp_granted_ff, rsp_granted_in;
   logic              rsp_fresh_ff, rsp_fresh_in;
   logic [USED_W-1:0] rsp_used_ff, rsp_used_in;
   logic              rsp_fault_ff, rsp_fault_in;

   // datapath helpers
   logic              req_acc;
   logic              out_free;
   logic              commit;
   logic [RND_W-1:0]  asz_full;
   logic [RND_W-1:0]  pos_full;
   logic [BSZ_W+1:0]  fit_end;
   logic              need_new;
   logic              have_free;
   logic              fresh_ok;
   logic              rec_full;
   logic              alloc_ok;
   logic              use_fresh;
   logic [BSZ_W:0]    start;
   logic [BSZ_W+1:0]  fill_sum;
   logic [CNT_W-1:0]  free_top_idx;
   logic [USED_SUM_W-1:0] used_sum;

   bpa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   bpa_stacks u_stacks (
      .clock (clock),
      .ctl   (stk_ctl),
      .dat   (stk_dat)
   );

   assign req_bus.ready = !reset && (state_ff == ST_IDLE);
   assign req_acc       = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   // size rounding in the accept cycle
   assign asz_full = round_up(RND_W'(req_bus.req_size), cfg.align_log2);
   assign pos_full = round_up(RND_W'(fill_ff), cfg.align_log2);

   // fit check in the execute cycle
   assign fit_end   = (BSZ_W+2)'(pos_ff) + (BSZ_W+2)'(asz_ff);
   assign need_new  = !cur_valid_ff || (fit_end > (BSZ_W+2)'(cfg.block_size));
   assign have_free = (free_count_ff != '0);
   assign fresh_ok  = (next_fresh_ff < CNT_W'(MAX_BLOCKS));
   assign rec_full  = cur_valid_ff && (recycle_count_ff >= CNT_W'(MAX_BLOCKS));
   assign alloc_ok  = !need_new || ((have_free || fresh_ok) && !rec_full);
   assign use_fresh = need_new && !have_free;
   assign start     = need_new ? '0 : pos_ff;
   assign fill_sum  = (BSZ_W+2)'(start) + (BSZ_W+2)'(asz_ff);

   // top of free stack
   assign free_top_idx = free_count_ff - CNT_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_bus.cmd == CMD_ALLOC) begin
                  state_in = ST_EXEC;
               end else if (recycle_count_ff == '0) begin
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_RD: begin
            state_in = ST_WR;
         end
         ST_WR: begin
            if (walk_idx_ff + CNT_W'(1) == recycle_count_ff) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_RD;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and memory control per state
   always_comb begin
      cmd_in           = cmd_ff;
      req_size_in      = req_size_ff;
      asz_in           = asz_ff;
      over_in          = over_ff;
      pos_in           = pos_ff;
      cur_valid_in     = cur_valid_ff;
      cur_block_in     = cur_block_ff;
      fill_in          = fill_ff;
      free_count_in    = free_count_ff;
      recycle_count_in = recycle_count_ff;
      next_fresh_in    = next_fresh_ff;
      oneshot_in       = oneshot_ff;
      walk_idx_in      = walk_idx_ff;
      commit           = 1'b0;
      rsp_block_id_in  = '0;
      rsp_over_in      = 1'b0;
      rsp_offset_in    = '0;
      rsp_granted_in   = '0;
      rsp_fresh_in     = 1'b0;
      rsp_fault_in     = 1'b0;
      // stack read addresses: top of free stack, current walk entry
      stk_ctl.free_raddr = free_top_idx[IDX_W-1:0];
      stk_ctl.rec_raddr  = walk_idx_ff[IDX_W-1:0];
      stk_ctl.free_we    = 1'b0;
      stk_ctl.free_waddr = free_count_ff[IDX_W-1:0];
      stk_ctl.free_wdata = stk_dat.rec_entry;
      stk_ctl.rec_we     = 1'b0;
      stk_ctl.rec_waddr  = recycle_count_ff[IDX_W-1:0];
      stk_ctl.rec_wdata  = cur_block_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               cmd_in      = req_bus.cmd;
               req_size_in = req_bus.req_size;
               asz_in      = asz_full[BSZ_W-1:0];
               over_in     = asz_full > RND_W'(cfg.block_size);
               pos_in      = pos_full[BSZ_W:0];
               walk_idx_in = '0;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               commit = 1'b1;
               if (over_ff) begin
                  // oversized: one-shot slot, current block untouched
                  if (oneshot_ff >= OS_W'(MAX_ONESHOTS)) begin
                     rsp_fault_in = 1'b1;
                  end else begin
                     rsp_block_id_in = ID_W'(oneshot_ff);
                     oneshot_in      = oneshot_ff + OS_W'(1);
                     rsp_over_in     = 1'b1;
                     rsp_granted_in  = req_size_ff;
                  end
               end else if (!alloc_ok) begin
                  rsp_fault_in = 1'b1;
               end else begin
                  if (need_new) begin
                     // retire current block, take a pooled or fresh id
                     if (use_fresh) begin
                        next_fresh_in = next_fresh_ff + CNT_W'(1);
                        cur_block_in  = ID_W'(next_fresh_ff);
                     end else begin
                        free_count_in = free_count_ff - CNT_W'(1);
                        cur_block_in  = stk_dat.free_top;
                     end
                     if (cur_valid_ff) begin
                        stk_ctl.rec_we   = 1'b1;
                        recycle_count_in = recycle_count_ff + CNT_W'(1);
                     end
                     cur_valid_in = 1'b1;
                  end
                  rsp_block_id_in = cur_block_in;
                  rsp_offset_in   = (start > (BSZ_W+1)'(OFF_SAT)) ? OFF_SAT
                                                                : start[OFF_W-1:0];
                  rsp_granted_in  = req_size_ff;
                  rsp_fresh_in    = use_fresh;
                  fill_in         = fill_sum[BSZ_W-1:0];
               end
            end
         end
         ST_RD: begin
            // recycle entry read is in flight
         end
         ST_WR: begin
            // push the recycled id onto the free stack
            if (free_count_ff < CNT_W'(MAX_BLOCKS)) begin
               stk_ctl.free_we = 1'b1;
               free_count_in   = free_count_ff + CNT_W'(1);
            end
            walk_idx_in = walk_idx_ff + CNT_W'(1);
         end
         ST_FIN: begin
            if (out_free) begin
               commit           = 1'b1;
               recycle_count_in = '0;
               oneshot_in       = '0;
               fill_in          = '0;
               walk_idx_in      = '0;
            end
         end
         default: begin
            commit = 1'b0;
         end
      endcase
   end

   // block count reported after the step
   assign used_sum    = USED_SUM_W'(cur_valid_in) + USED_SUM_W'(recycle_count_in)
                      + USED_SUM_W'(oneshot_in);
   assign rsp_used_in = USED_W'(used_sum);

   // response register: loads on commit, drains on a taken beat
   assign rsp_valid_in = commit || (rsp_valid_ff && !rsp_bus.ready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         cur_valid_ff     <= 1'b0;
         cur_block_ff     <= '0;
         fill_ff          <= '0;
         free_count_ff    <= '0;
         recycle_count_ff <= '0;
         next_fresh_ff    <= '0;
         oneshot_ff       <= '0;
         walk_idx_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         cur_valid_ff     <= cur_valid_in;
         cur_block_ff     <= cur_block_in;
         fill_ff          <= fill_in;
         free_count_ff    <= free_count_in;
         recycle_count_ff <= recycle_count_in;
         next_fresh_ff    <= next_fresh_in;
         oneshot_ff       <= oneshot_in;
         walk_idx_ff      <= walk_idx_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      req_size_ff <= req_size_in;
      asz_ff      <= asz_in;
      over_ff     <= over_in;
      pos_ff      <= pos_in;
      if (commit) begin
         rsp_block_id_ff <= rsp_block_id_in;
         rsp_over_ff     <= rsp_over_in;
         rsp_offset_ff   <= rsp_offset_in;
         rsp_granted_ff  <= rsp_granted_in;
         rsp_fresh_ff    <= rsp_fresh_in;
         rsp_used_ff     <= rsp_used_in;
         rsp_fault_ff    <= rsp_fault_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.block_id     = rsp_block_id_ff;
   assign rsp_bus.is_oversized = rsp_over_ff;
   assign rsp_bus.offset       = rsp_offset_ff;
   assign rsp_bus.granted_size = rsp_granted_ff;
   assign rsp_bus.fresh_block  = rsp_fresh_ff;
   assign rsp_bus.used_blocks  = rsp_used_ff;
   assign rsp_bus.fault        = rsp_fault_ff;

   // every id handed out is current, recycled, free or mid-walk
   a_id_conservation: assert property (@(posedge clock) disable iff (reset)
      (CNT_W+2)'(free_count_ff) + (CNT_W+2)'(recycle_count_ff)
         + (CNT_W+2)'(cur_valid_ff)
      == (CNT_W+2)'(next_fresh_ff) + (CNT_W+2)'(walk_idx_ff))
      else $error("block id accounting broken");
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD || state_ff == ST_WR) |-> walk_idx_ff < recycle_count_ff)
      else $error("recycle walk past list end");
   a_fault_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && commit && rsp_fault_in)
      |=> $stable(free_count_ff) && $stable(next_fresh_ff)
          && $stable(oneshot_ff) && $stable(recycle_count_ff))
      else $error("faulted allocation changed state");
   a_counts_bound: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= CNT_W'(MAX_BLOCKS) && oneshot_ff <= OS_W'(MAX_ONESHOTS))
      else $error("pool count above limit");

endmodule

>>> bench/block_pool_bump_allocator_top_test.sv
// block_pool_bump_allocator_top_test: self-checking bench for the block pool bump allocator
// drives request and register channels, predicts every grant and compares response beats
// depends on bpa_pkg, bpa_if and block_pool_bump_allocator_top
module block_pool_bump_allocator_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import bpa_pkg::*;

   localparam int STALL_LIMIT    = 3000;
   localparam int RX_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES  = 40;

   typedef struct packed {
      logic [ID_W-1:0]   block_id;
      logic              is_oversized;
      logic [OFF_W-1:0]  offset;
      logic [SIZE_W-1:0] granted_size;
      logic              fresh_block;
      logic [USED_W-1:0] used_blocks;
      logic              fault;
   } grant_type;

   typedef struct {
      cmd_type           cmd;
      logic [SIZE_W-1:0] size;
   } alloc_req_type;

   logic clock;
   logic reset;

   bpa_req_if req_ch ();
   bpa_rsp_if rsp_ch ();
   bpa_csr_if csr_ch ();

   block_pool_bump_allocator_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .csr_bus (csr_ch)
   );

   alloc_req_type pending_reqs[$];
   grant_type     expected_grants[$];
   int         mismatch_count = 0;
   int         tx_idle_pct = 0;
   int         rx_idle_pct = 0;
   logic       rx_stall_armed = 1'b0;
   logic       rx_hold_taken;
   int         rx_hold_left;
   int         quiet_cycles;

   // allocator shadow: configuration and pool state
   logic [ALIGN_W-1:0] pool_align = ALIGN_RESET;
   logic [BSZ_W-1:0]   pool_bsz   = BSZ_RESET;
   logic               cur_valid  = 1'b0;
   logic [ID_W-1:0]    cur_block  = '0;
   logic [BSZ_W-1:0]   fill_off   = '0;
   logic [ID_W-1:0]    free_stk [MAX_BLOCKS];
   logic [ID_W-1:0]    rec_list [MAX_BLOCKS];
   int                 free_cnt   = 0;
   int                 rec_cnt    = 0;
   int                 next_fresh = 0;
   int                 os_cnt     = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [63:0] align_up(logic [63:0] v, int lg);
      logic [63:0] m;
      m = (64'd1 << lg) - 64'd1;
      return (v + m) & ~m;
   endfunction

   // next grant of the allocator; updates the shadow state
   function automatic grant_type predict_grant(cmd_type cmd, logic [SIZE_W-1:0] size);
      logic [63:0]     bsz;
      logic [63:0]     asz;
      logic [63:0]     pos;
      logic [ID_W-1:0] nb;
      logic            take_fresh;
      logic            ok;
      int              lg;
      grant_type       g;
      lg  = (pool_align > ALIGN_MAX) ? int'(ALIGN_MAX) : int'(pool_align);
      bsz = (pool_bsz == 0) ? 64'd1 : ((pool_bsz > BSZ_MAX) ? 64'(BSZ_MAX) : 64'(pool_bsz));
      g   = '0;
      if (cmd == CMD_FRAME_RESET) begin
         // recycled ids go back onto the free stack in list order
         for (int i = 0; i < rec_cnt; i++) begin
            if (free_cnt < MAX_BLOCKS) begin
               free_stk[free_cnt] = rec_list[i];
               free_cnt++;
            end
         end
         rec_cnt  = 0;
         os_cnt   = 0;
         fill_off = '0;
      end else begin
         asz = align_up(64'(size), lg);
         if (asz > bsz) begin
            // one-shot slot, current block untouched
            if (os_cnt >= MAX_ONESHOTS) begin
               g.fault = 1'b1;
            end else begin
               g.block_id     = ID_W'(os_cnt);
               g.is_oversized = 1'b1;
               g.granted_size = size;
               os_cnt++;
            end
         end else begin
            pos        = align_up(64'(fill_off), lg);
            ok         = 1'b1;
            take_fresh = 1'b0;
            nb         = '0;
            if (!cur_valid || (pos + asz > bsz)) begin
               if (free_cnt > 0) begin
                  nb = free_stk[free_cnt-1];
               end else if (next_fresh < MAX_BLOCKS) begin
                  nb         = ID_W'(next_fresh);
                  take_fresh = 1'b1;
               end else begin
                  ok = 1'b0;
               end
               if (ok && cur_valid && rec_cnt >= MAX_BLOCKS) ok = 1'b0;
               if (ok) begin
                  if (take_fresh) next_fresh++;
                  else free_cnt--;
                  if (cur_valid) begin
                     rec_list[rec_cnt] = cur_block;
                     rec_cnt++;
                  end
                  cur_block = nb;
                  cur_valid = 1'b1;
                  pos       = '0;
               end
            end
            if (ok) begin
               g.block_id     = cur_block;
               g.offset       = (pos > 64'(OFF_SAT)) ? OFF_SAT : pos[OFF_W-1:0];
               g.granted_size = size;
               g.fresh_block  = take_fresh;
               fill_off       = BSZ_W'(pos + asz);
            end else begin
               g.fault = 1'b1;
            end
         end
      end
      g.used_blocks = USED_W'(int'(cur_valid) + rec_cnt + os_cnt);
      return g;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      $display("%0t ns: mismatch on %s, expected 0x%0h, got 0x%0h", $time, what, want, got);
      mismatch_count++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch(name, want, got);
   endtask

   // request driver: holds a beat until taken, idles at random
   always @(posedge clock) begin : req_driver
      alloc_req_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_grants.push_back(predict_grant(req_ch.cmd, req_ch.req_size));
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
               nxt = pending_reqs.pop_front();
               req_ch.valid    <= 1'b1;
               req_ch.cmd      <= nxt.cmd;
               req_ch.req_size <= nxt.size;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, taken once when armed
   always @(posedge clock) begin
      if (reset) begin
         rx_hold_left  <= 0;
         rx_hold_taken <= 1'b0;
      end else if (rx_stall_armed && !rx_hold_taken) begin
         rx_hold_left  <= RX_HOLD_CYCLES;
         rx_hold_taken <= 1'b1;
      end else if (rx_hold_left != 0) begin
         rx_hold_left <= rx_hold_left - 1;
      end
   end

   // response monitor: compares each beat with the oldest predicted grant
   always @(posedge clock) begin : grant_monitor
      grant_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_grants.size() == 0) begin
               report_mismatch("response beat with no grant pending", 0, rsp_ch.block_id);
            end else begin
               want = expected_grants.pop_front();
               check_field("block_id", rsp_ch.block_id, want.block_id);
               check_field("is_oversized", rsp_ch.is_oversized, want.is_oversized);
               check_field("offset", rsp_ch.offset, want.offset);
               check_field("granted_size", rsp_ch.granted_size, want.granted_size);
               check_field("fresh_block", rsp_ch.fresh_block, want.fresh_block);
               check_field("used_blocks", rsp_ch.used_blocks, want.used_blocks);
               check_field("fault", rsp_ch.fault, want.fault);
            end
         end
         rsp_ch.ready <= (rx_hold_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                   (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_req(cmd_type c, logic [SIZE_W-1:0] s);
      alloc_req_type r;
      r.cmd  = c;
      r.size = s;
      pending_reqs.push_back(r);
   endtask

   // wait until every grant is back, then let a frame reset walk finish
   task automatic drain();
      while (pending_reqs.size() != 0 || req_ch.valid || expected_grants.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // both registers, back to back; align beat carries random upper data bits
   task automatic set_config(logic [ALIGN_W-1:0] lg, logic [BSZ_W-1:0] bsz);
      logic [BSZ_W-ALIGN_W-1:0] pad;
      drain();
      pad = (BSZ_W-ALIGN_W)'($urandom);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= CSR_ALIGN_LOG2;
      csr_ch.data  <= {pad, lg};
      do @(posedge clock); while (!csr_ch.ready);
      pool_align = lg;
      csr_ch.index <= CSR_BLOCK_SIZE;
      csr_ch.data  <= bsz;
      do @(posedge clock); while (!csr_ch.ready);
      pool_bsz = bsz;
      csr_ch.valid <= 1'b0;
   endtask

   // size picker: 0 oversized frame, 1 block-sized frame, else mixed
   function automatic logic [SIZE_W-1:0] pick_size(logic [31:0] eff, int kind);
      int r;
      r = $urandom_range(0, 9);
      if (kind == 0) return (r < 5) ? $urandom : eff + 1 + $urandom_range(0, 1 << 20);
      if (kind == 1) return $urandom_range(eff, eff / 2);
      case (r)
         0: return $urandom;
         1: return 0;
         2: return eff;
         3: return eff + $urandom_range(1, 4096);
         4: return eff - $urandom_range(0, (eff > 64) ? 64 : eff);
         default: return $urandom_range(0, eff / 6);
      endcase
   endfunction

   // frames of allocations closed by a frame reset, some left open, some noise
   task automatic random_phase(int n, logic [ALIGN_W-1:0] lg, logic [BSZ_W-1:0] bsz,
                               int tx_pct, int rx_pct);
      int          made;
      int          len;
      int          kind;
      logic [31:0] eff;
      set_config(lg, bsz);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      eff  = (bsz == 0) ? 32'd1 : ((bsz > BSZ_MAX) ? 32'(BSZ_MAX) : 32'(bsz));
      made = 0;
      while (made < n) begin
         kind = $urandom_range(0, 9);
         case (kind)
            0: len = $urandom_range(10, 20);
            1: len = $urandom_range(8, 22);
            2: len = $urandom_range(1, 6);
            default: len = $urandom_range(1, 30);
         endcase
         for (int k = 0; k < len; k++) begin
            if (kind == 2) push_req(cmd_type'($urandom_range(0, 1)), $urandom);
            else push_req(CMD_ALLOC, pick_size(eff, kind));
         end
         made += len;
         if (kind != 2 && $urandom_range(0, 5) != 0) begin
            push_req(CMD_FRAME_RESET, $urandom);
            made++;
         end
      end
   endtask

   // stimulus sequence and verdict
   initial begin
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.cmd      = CMD_ALLOC;
      req_ch.req_size = '0;
      rsp_ch.ready    = 1'b0;
      csr_ch.valid    = 1'b0;
      csr_ch.index    = CSR_ALIGN_LOG2;
      csr_ch.data     = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      tx_idle_pct = 9;
      rx_idle_pct = 86;

      // reset configuration: first allocation, one-shots, block rollover, reuse
      push_req(CMD_ALLOC, 32'd0);
      push_req(CMD_ALLOC, 32'd1);
      push_req(CMD_ALLOC, 32'hFFFF_FFFF);
      push_req(CMD_ALLOC, 32'd65536);
      push_req(CMD_ALLOC, 32'd65537);
      push_req(CMD_ALLOC, 32'd255);
      push_req(CMD_FRAME_RESET, 32'd0);
      push_req(CMD_ALLOC, 32'd100);
      push_req(CMD_ALLOC, 32'd65536);
      push_req(CMD_FRAME_RESET, 32'hFFFF_FFFF);

      // alignment above range and zero block size are clamped
      set_config(4'd15, 25'd0);
      push_req(CMD_ALLOC, 32'd0);
      push_req(CMD_ALLOC, 32'd1);
      push_req(CMD_ALLOC, 32'd0);
      push_req(CMD_FRAME_RESET, 32'd0);

      // block size above range; full block then zero size saturates the offset
      set_config(4'd0, 25'h1FF_FFFF);
      push_req(CMD_ALLOC, 32'd16777216);
      push_req(CMD_ALLOC, 32'd0);
      push_req(CMD_ALLOC, 32'd3);
      push_req(CMD_ALLOC, 32'h8000_0000);
      push_req(CMD_FRAME_RESET, 32'd0);

      // alignment raised mid-frame pads the fill offset
      set_config(4'd0, 25'd1000);
      push_req(CMD_ALLOC, 32'd3);
      set_config(4'd4, 25'd1000);
      push_req(CMD_ALLOC, 32'd5);
      push_req(CMD_ALLOC, 32'd1000);
      push_req(CMD_FRAME_RESET, 32'd0);

      // random frames under three idling patterns
      random_phase(110, 4'd2, 25'd256, 9, 86);
      random_phase(110, 4'd5, 25'd5000, 9, 86);
      random_phase(110, 4'd12, 25'd16777216, 86, 9);
      random_phase(110, 4'd0, 25'd1, 86, 9);
      random_phase(110, 4'd3, 25'd777, 0, 0);
      rx_stall_armed = 1'b1;
      random_phase(110, 4'd13, 25'd100000, 0, 0);

      drain();
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
